// File: hw/rtl/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg: shared definitions for the linear interpolation resampler
// Widths, register indexes, sequencer step codes and the control store.
// ----------------------------------------------------------------------------
package lirs_pkg;

  localparam int CHANNELS        = 4;
  localparam int SAMPLE_W        = 16;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_W         = PHASE_FRAC_BITS + 4;
  localparam int MAX_UPSAMPLE    = 16;
  localparam int CNT_W           = $clog2(MAX_UPSAMPLE + 1);
  localparam int CHCNT_W         = 3;
  localparam int CFG_W           = PHASE_W;
  localparam int CFG_IDX_W       = 1;
  localparam int DIFF_W          = SAMPLE_W + 1;
  localparam int PROD_W          = DIFF_W + PHASE_FRAC_BITS;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_CNT   = 1'd1;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = PHASE_W'(65536);
  localparam logic [CHCNT_W-1:0] CHAN_CNT_RST   = CHCNT_W'(2);

  typedef logic signed [SAMPLE_W-1:0] pcm_t;

  // Sequencer steps
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_SORT  = 3'd1,
    ST_PRIME = 3'd2,
    ST_CHECK = 3'd3,
    ST_EMIT  = 3'd4,
    ST_WRAP  = 3'd5
  } step_t;

  // Branch conditions
  typedef enum logic [2:0] {
    CND_ALWAYS,
    CND_ACCEPT,
    CND_UNPRIMED,
    CND_DONE,
    CND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t jmp_t;      // taken when cond holds
    step_t jmp_f;      // taken otherwise
    logic  take_in;    // open the input channel
    logic  emit;       // load the output register
    logic  st_prev;    // current frame becomes previous
    logic  set_primed;
    logic  wrap;       // phase less one period (else cleared); clear run count
  } ctrl_word_t;

  function automatic ctrl_word_t ctrl_rom(step_t pc);
    ctrl_word_t w;
    w = '{cond: CND_ALWAYS, jmp_t: ST_IDLE, jmp_f: ST_IDLE, take_in: 1'b0,
          emit: 1'b0, st_prev: 1'b0, set_primed: 1'b0, wrap: 1'b0};
    case (pc)
      ST_IDLE: begin
        w.cond    = CND_ACCEPT;
        w.jmp_t   = ST_SORT;
        w.jmp_f   = ST_IDLE;
        w.take_in = 1'b1;
      end
      ST_SORT: begin
        w.cond  = CND_UNPRIMED;
        w.jmp_t = ST_PRIME;
        w.jmp_f = ST_CHECK;
      end
      ST_PRIME: begin
        w.st_prev    = 1'b1;
        w.set_primed = 1'b1;
      end
      ST_CHECK: begin
        w.cond  = CND_DONE;
        w.jmp_t = ST_WRAP;
        w.jmp_f = ST_EMIT;
      end
      ST_EMIT: begin
        w.cond  = CND_OUT_BUSY;
        w.jmp_t = ST_EMIT;
        w.jmp_f = ST_CHECK;
        w.emit  = 1'b1;
      end
      ST_WRAP: begin
        w.st_prev = 1'b1;
        w.wrap    = 1'b1;
      end
      default: begin
        w.jmp_t = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler: linear interpolation sample rate converter
// Up to four channels per frame, Q16 phase step, microcoded control.
// ----------------------------------------------------------------------------
// Each accepted input frame produces between zero and sixteen output frames,
// interpolated between the previous and the current frame at the running
// phase and rounded toward minus infinity; the first frame after reset only
// primes the block and gives no output. Control is a six-step microprogram,
// and each output frame costs one pass through its two-step check/emit loop,
// which waits in the emit step for as long as the output side holds stall high.
// Channels at or above the channel count register are forced to zero. Write
// configuration only while the block is idle.
module linear_interp_resampler (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lirs_pkg::pcm_t                     in_ch0,
  input  lirs_pkg::pcm_t                     in_ch1,
  input  lirs_pkg::pcm_t                     in_ch2,
  input  lirs_pkg::pcm_t                     in_ch3,
  output logic                               out_valid,
  input  logic                               out_stall,
  output lirs_pkg::pcm_t                     out_ch0,
  output lirs_pkg::pcm_t                     out_ch1,
  output lirs_pkg::pcm_t                     out_ch2,
  output lirs_pkg::pcm_t                     out_ch3,
  output logic                               out_last_of_run,
  input  logic                               cfg_we,
  input  logic [lirs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lirs_pkg::CFG_W-1:0]         cfg_wdata
);
  import lirs_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_UPSAMPLE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_UPSAMPLE - 1);
  localparam logic [PHASE_W-1:0] PERIOD = PHASE_W'(1) << PHASE_FRAC_BITS;

  step_t                    pc_r;
  ctrl_word_t               cw;
  logic                     cond;

  logic [PHASE_W-1:0]       phase_step_r;
  logic [CHCNT_W-1:0]       chan_cnt_r;
  logic [PHASE_W-1:0]       phase_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     primed_r;

  pcm_t                     in_arr [CHANNELS];
  pcm_t                     cur_r  [CHANNELS];
  pcm_t                     prev_r [CHANNELS];
  logic signed [PROD_W-1:0] prod_r [CHANNELS];
  pcm_t                     out_r  [CHANNELS];
  logic                     out_valid_r;
  logic                     out_last_r;

  logic                     in_acc;
  logic                     out_acc;
  logic                     out_busy;
  logic                     phase_ge;
  logic                     run_done;
  logic [PHASE_W:0]         phase_sum;
  logic [PHASE_W-1:0]       phase_adv;
  logic                     do_emit;

  assign in_arr[0] = in_ch0;
  assign in_arr[1] = in_ch1;
  assign in_arr[2] = in_ch2;
  assign in_arr[3] = in_ch3;

  assign cw        = ctrl_rom(pc_r);
  assign in_stall  = !cw.take_in;
  assign in_acc    = in_valid && cw.take_in;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_busy  = out_valid_r && out_stall;
  assign phase_ge  = |phase_r[PHASE_W-1:PHASE_FRAC_BITS];
  assign run_done  = phase_ge || (cnt_r == CNT_MAX);
  assign phase_sum = {1'b0, phase_r} + {1'b0, phase_step_r};
  // saturate on overflow of the phase word
  assign phase_adv = phase_sum[PHASE_W] ? '1 : phase_sum[PHASE_W-1:0];
  assign do_emit   = cw.emit && !out_busy;

  always_comb begin
    case (cw.cond)
      CND_ALWAYS:   cond = 1'b1;
      CND_ACCEPT:   cond = in_valid;
      CND_UNPRIMED: cond = !primed_r;
      CND_DONE:     cond = run_done;
      CND_OUT_BUSY: cond = out_busy;
      default:      cond = 1'b1;
    endcase
  end

  // Sequencer and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= ST_IDLE;
      phase_step_r <= PHASE_STEP_RST;
      chan_cnt_r   <= CHAN_CNT_RST;
      phase_r      <= '0;
      cnt_r        <= '0;
      primed_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r <= cond ? cw.jmp_t : cw.jmp_f;
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_STEP: phase_step_r <= cfg_wdata;
          REG_CHAN_CNT:   chan_cnt_r   <= cfg_wdata[CHCNT_W-1:0];
          default: ;
        endcase
      end
      if (cw.set_primed) begin
        primed_r <= 1'b1;
      end
      if (do_emit) begin
        phase_r     <= phase_adv;
        cnt_r       <= cnt_r + CNT_W'(1);
        out_valid_r <= 1'b1;
      end else begin
        if (out_acc) begin
          out_valid_r <= 1'b0;
        end
        if (cw.wrap) begin
          phase_r <= phase_ge ? (phase_r - PERIOD) : '0;
          cnt_r   <= '0;
        end
      end
    end
  end

  // Datapath: one multiplier lane per channel, products registered before the add
  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      logic signed [DIFF_W-1:0]   diff;
      logic signed [DIFF_W-1:0]   ph;
      logic signed [2*DIFF_W-1:0] prod;
      logic signed [SAMPLE_W+1:0] sum;
      diff = {cur_r[c][SAMPLE_W-1], cur_r[c]} - {prev_r[c][SAMPLE_W-1], prev_r[c]};
      ph   = {1'b0, phase_r[PHASE_FRAC_BITS-1:0]};
      prod = diff * ph;
      prod_r[c] <= prod[PROD_W-1:0];
      // arithmetic shift gives the floor of the scaled difference
      sum = {{2{prev_r[c][SAMPLE_W-1]}}, prev_r[c]}
          + {prod_r[c][PROD_W-1], prod_r[c][PROD_W-1:PHASE_FRAC_BITS]};
      if (in_acc) begin
        cur_r[c] <= (CHCNT_W'(c) < chan_cnt_r) ? in_arr[c] : '0;
      end
      if (cw.st_prev) begin
        prev_r[c] <= cur_r[c];
      end
      if (do_emit) begin
        out_r[c] <= sum[SAMPLE_W-1:0];
      end
    end
    if (do_emit) begin
      out_last_r <= phase_adv[PHASE_W-1:PHASE_FRAC_BITS] != '0 || cnt_r == CNT_LAST;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ch0         = out_r[0];
  assign out_ch1         = out_r[1];
  assign out_ch2         = out_r[2];
  assign out_ch3         = out_r[3];
  assign out_last_of_run = out_last_r;

endmodule

// File: hw/rtl/lirs_chk.sv
// ----------------------------------------------------------------------------
// lirs_chk: port-level checks for the linear interpolation resampler
// Watches the top level's handshakes over time; bound to the top level.
// ----------------------------------------------------------------------------
module lirs_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input lirs_pkg::pcm_t                 out_ch0,
  input lirs_pkg::pcm_t                 out_ch1,
  input lirs_pkg::pcm_t                 out_ch2,
  input lirs_pkg::pcm_t                 out_ch3,
  input logic                           out_last_of_run
);
  import lirs_pkg::*;

  // No output request survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // An accepted frame occupies the sequencer for the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a frame");

  // A run is not over until its last request has gone
  a_run_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> in_stall)
    else $error("input taken in the middle of a run");

  // Hold a stalled request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ch0) && $stable(out_ch1)
      && $stable(out_ch2) && $stable(out_ch3) && $stable(out_last_of_run))
    else $error("stalled output request changed");

endmodule

bind linear_interp_resampler lirs_chk u_lirs_chk (.*);

// File: tb/linear_interp_resampler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_test: self-checking bench for the resampler
// Drives input frames through the valid/stall handshake under several phase
// step and channel count settings, predicts every interpolated output frame
// in a small scoreboard and compares each accepted output frame in order.
// ----------------------------------------------------------------------------
import lirs_pkg::*;

typedef pcm_t frame_t [CHANNELS];

typedef struct {
  frame_t ch;
  logic   last_of_run;
} out_frame_t;

class interp_frames;
  localparam logic [PHASE_W-1:0] PERIOD = PHASE_W'(1) << PHASE_FRAC_BITS;

  logic [PHASE_W-1:0] phase_step;
  logic [CHCNT_W-1:0] chan_count;
  logic [PHASE_W-1:0] phase;
  frame_t             prev;
  bit                 primed;
  out_frame_t         pending[$];
  int                 mismatch_count;

  function new();
    phase_step     = PHASE_STEP_RST;
    chan_count     = CHAN_CNT_RST;
    phase          = '0;
    primed         = 1'b0;
    mismatch_count = 0;
    foreach (prev[c]) prev[c] = '0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    if (idx == REG_PHASE_STEP) begin
      phase_step = value[PHASE_W-1:0];
    end else if (idx == REG_CHAN_CNT) begin
      chan_count = value[CHCNT_W-1:0];
    end
  endfunction

  // Work out every output frame that one accepted input frame causes.
  function void take_frame(frame_t f);
    frame_t         cur;
    out_frame_t     o;
    int             n;
    longint         d;
    logic [PHASE_W:0] nxt;
    foreach (cur[c]) cur[c] = (c < chan_count) ? f[c] : pcm_t'(0);
    if (!primed) begin
      prev   = cur;
      primed = 1'b1;
      return;
    end
    n = 0;
    while (phase < PERIOD && n < MAX_UPSAMPLE) begin
      foreach (o.ch[c]) begin
        d = longint'(cur[c]) - longint'(prev[c]);
        o.ch[c] = pcm_t'(longint'(prev[c]) +
                         ((d * longint'(phase)) >>> PHASE_FRAC_BITS));
      end
      n++;
      nxt = {1'b0, phase} + {1'b0, phase_step};
      // saturate rather than wrap the phase
      phase = nxt[PHASE_W] ? '1 : nxt[PHASE_W-1:0];
      o.last_of_run = !(phase < PERIOD && n < MAX_UPSAMPLE);
      pending.push_back(o);
    end
    if (phase >= PERIOD) phase = phase - PERIOD;
    else phase = '0;
    prev = cur;
  endfunction

  task report_mismatch(string msg);
    mismatch_count++;
    $display("mismatch: %s", msg);
  endtask

  task match_frame(frame_t got, logic got_last);
    out_frame_t want;
    if (pending.size() == 0) begin
      report_mismatch($sformatf("output frame %0d %0d %0d %0d with none pending",
                                got[0], got[1], got[2], got[3]));
      return;
    end
    want = pending.pop_front();
    foreach (got[c]) begin
      if (got[c] !== want.ch[c]) begin
        report_mismatch($sformatf("out_ch%0d got %0d expected %0d",
                                  c, got[c], want.ch[c]));
      end
    end
    if (got_last !== want.last_of_run) begin
      report_mismatch($sformatf("out_last_of_run got %b expected %b",
                                got_last, want.last_of_run));
    end
  endtask
endclass

module linear_interp_resampler_test;

  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 400;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  pcm_t                 in_ch0 = '0;
  pcm_t                 in_ch1 = '0;
  pcm_t                 in_ch2 = '0;
  pcm_t                 in_ch3 = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  pcm_t                 out_ch0;
  pcm_t                 out_ch1;
  pcm_t                 out_ch2;
  pcm_t                 out_ch3;
  logic                 out_last_of_run;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  interp_frames sb;
  bit           tx_idle_en = 1'b1;
  bit           rx_idle_en = 1'b1;
  int           hold_request = 0;
  int           cycles = 0;

  linear_interp_resampler i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_ch0          (in_ch0),
    .in_ch1          (in_ch1),
    .in_ch2          (in_ch2),
    .in_ch3          (in_ch3),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ch0         (out_ch0),
    .out_ch1         (out_ch1),
    .out_ch2         (out_ch2),
    .out_ch3         (out_ch3),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("linear_interp_resampler_test: errors");
    $finish;
  end

  // Output side: check accepted frames, stall in bursts or for a long hold-off.
  initial begin
    int     burst;
    int     hold_left;
    frame_t got;
    burst     = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        got = '{out_ch0, out_ch1, out_ch2, out_ch3};
        sb.match_frame(got, out_last_of_run);
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_frame(input int s0, input int s1,
                            input int s2, input int s3);
    frame_t f;
    f = '{pcm_t'(s0), pcm_t'(s1), pcm_t'(s2), pcm_t'(s3)};
    in_valid <= 1'b1;
    in_ch0   <= f[0];
    in_ch1   <= f[1];
    in_ch2   <= f[2];
    in_ch3   <= f[3];
    // hold the request until the block takes it
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.take_frame(f);
  endtask

  task automatic sender_gap();
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic await_quiet();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [PHASE_W-1:0] step,
                           input logic [CHCNT_W-1:0] count);
    logic [CFG_W-1:0] word;
    // stray upper bits on the count write are ignored by the register
    word = CFG_W'($urandom);
    word[CHCNT_W-1:0] = count;
    cfg_we    <= 1'b1;
    cfg_index <= REG_PHASE_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    sb.set_reg(REG_PHASE_STEP, step);
    cfg_index <= REG_CHAN_CNT;
    cfg_wdata <= word;
    @(posedge clk);
    sb.set_reg(REG_CHAN_CNT, word);
    cfg_we <= 1'b0;
  endtask

  function automatic pcm_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return pcm_t'(32767);
      1:       return pcm_t'(-32768);
      2:       return pcm_t'($urandom_range(0, 7)) - pcm_t'(4);
      default: return pcm_t'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  function automatic logic [PHASE_W-1:0] rand_step();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return PHASE_W'($urandom_range(1, 4095));
      2:       return '1;
      3:       return PHASE_W'($urandom_range(524289, 20'hfffff));
      4:       return PHASE_W'(4096);
      5:       return PHASE_W'(524288);
      default: return PHASE_W'($urandom_range(4096, 524288));
    endcase
  endfunction

  function automatic logic [CHCNT_W-1:0] rand_count();
    if ($urandom_range(0, 3) == 0) return CHCNT_W'($urandom_range(0, 7));
    return CHCNT_W'($urandom_range(1, 4));
  endfunction

  task automatic send_random(input int count);
    repeat (count) begin
      send_frame(int'(rand_sample()), int'(rand_sample()),
                 int'(rand_sample()), int'(rand_sample()));
      sender_gap();
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the first frame primes, the rest come out at phase zero.
    send_frame(32767, -32768, 1, -1);
    sender_gap();
    send_frame(-32768, 32767, 0, 0);
    sender_gap();
    send_frame(0, -1, 32767, -32768);
    await_quiet();

    // Finest step: sixteen frames each, full-scale swings both ways.
    configure(PHASE_W'(4096), CHCNT_W'(4));
    send_frame(32767, -32768, 32767, -32768);
    sender_gap();
    send_frame(-32768, 32767, -1, 0);
    await_quiet();

    // Below the finest step and zero step: the run cap drops the rest.
    configure(PHASE_W'(4095), CHCNT_W'(0));
    send_frame(1234, -1234, 5, -5);
    send_frame(-32768, 32767, 32767, -32768);
    await_quiet();
    configure('0, CHCNT_W'(3));
    send_frame(-32768, 32767, -32768, 32767);
    send_frame(32767, -32768, 100, -100);
    await_quiet();

    // Largest step saturates the phase, then frames give nothing.
    configure('1, CHCNT_W'(7));
    send_random(4);
    await_quiet();

    configure(PHASE_W'(524288), CHCNT_W'(1));
    send_random(4);
    await_quiet();
    configure(PHASE_W'(40000), CHCNT_W'(5));
    send_random(3);
    await_quiet();
    configure(PHASE_W'(100000), CHCNT_W'(6));
    send_random(3);
    await_quiet();

    for (int p = 0; p < 8; p++) begin
      if (p == 2) begin
        // Long hold-off on the output while frames keep coming.
        configure(PHASE_W'(4096), CHCNT_W'(4));
        tx_idle_en   = 1'b0;
        hold_request = HOLD_CYCLES;
      end else begin
        configure(rand_step(), rand_count());
        tx_idle_en = (p != 7);
        rx_idle_en = (p != 7);
      end
      send_random(12);
      await_quiet();
    end

    if (sb.mismatch_count == 0) begin
      $display("linear_interp_resampler_test: clean");
    end else begin
      $display("linear_interp_resampler_test: errors");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lirs_pkg.sv
hw/rtl/linear_interp_resampler.sv
hw/rtl/lirs_chk.sv
tb/linear_interp_resampler_test.sv
